/* design/plt_pkg.sv */
// plt_pkg: shared codes, field widths and controller/datapath handshake structs
// for the positional list table. No dependencies.
`timescale 1ns / 1ps

package plt_pkg;

	localparam int ACTION_W = 2;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_GET    = 2'd2,
		ACT_FIND   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD      = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_POS,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_P1,
		RD_POS
	} rd_sel_t;

	typedef struct packed {
		logic    load_req;
		idx_op_t idx_op;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_val;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cap_data;
		logic    cap_found;
		logic    set_status;
		status_t status;
		logic    out_load;
	} plt_cmd_t;

	typedef struct packed {
		action_t action;
		logic    bad;
		logic    ins_more;
		logic    er_more;
		logic    find_more;
		logic    match;
		logic    out_busy;
	} plt_sts_t;

endpackage

/* design/plt_if.sv */
// plt_if: request and response channel interfaces (valid/ready plus payload).
// Depends on plt_pkg for field widths.
`timescale 1ns / 1ps

interface plt_in_if import plt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, action, position, value, input ready);
	modport sink (input valid, action, position, value, output ready);
endinterface

interface plt_out_if import plt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] data_out;
	logic [FOUND_W-1:0]        found_position;
	logic [COUNT_W-1:0]        element_count;

	modport source (output valid, status, data_out, found_position, element_count, input ready);
	modport sink (input valid, status, data_out, found_position, element_count, output ready);
endinterface

/* design/plt_datapath.sv */
// plt_datapath: list memory, element count, index counter, request and result
// registers. Driven by plt_ctrl through plt_cmd_t; depends on plt_pkg.
`timescale 1ns / 1ps

module plt_datapath import plt_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  plt_cmd_t                  cmd,
	output plt_sts_t                  sts,
	input  logic [ACTION_W-1:0]       req_action,
	input  logic [POS_W-1:0]          req_position,
	input  logic signed [VALUE_W-1:0] req_value,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [STATUS_W-1:0]       rsp_status,
	output logic signed [VALUE_W-1:0] rsp_data_out,
	output logic [FOUND_W-1:0]        rsp_found_position,
	output logic [COUNT_W-1:0]        rsp_element_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int VW = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

	logic [ELEM_WIDTH-1:0] mem [CAPACITY];

	action_t               act_q;
	logic [POS_W-1:0]      pos_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [ELEM_WIDTH-1:0] rd_q;

	status_t               res_status_q;
	logic [ELEM_WIDTH-1:0] res_data_q;
	logic [FOUND_W-1:0]    res_found_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [VALUE_W-1:0]    out_data_q;
	logic [FOUND_W-1:0]    out_found_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic [VW-1:0]         value_wide;
	logic [VW-1:0]         data_wide;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         count_x;
	logic [XW-1:0]         idx_x;
	logic [CW-1:0]         rd_addr;
	logic [ELEM_WIDTH-1:0] wr_data;

	assign value_wide = VW'($unsigned(req_value));
	assign data_wide  = VW'(res_data_q);
	assign pos_x      = XW'(pos_q);
	assign count_x    = XW'(count_q);
	assign idx_x      = XW'(idx_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_IDX_M1: rd_addr = idx_q - CW'(1);
			RD_IDX_P1: rd_addr = idx_q + CW'(1);
			RD_POS:    rd_addr = CW'(pos_x);
			default:   rd_addr = idx_q;
		endcase
	end

	assign wr_data = cmd.wr_val ? val_q : rd_q;

	// single-port style list storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[idx_q[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q <= action_t'(req_action);
			pos_q <= req_position;
			val_q <= value_wide[ELEM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			IDX_COUNT: idx_q <= count_q;
			IDX_POS:   idx_q <= CW'(pos_x);
			IDX_ZERO:  idx_q <= '0;
			IDX_INC:   idx_q <= idx_q + CW'(1);
			IDX_DEC:   idx_q <= idx_q - CW'(1);
			default:   idx_q <= idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			res_data_q  <= '0;
			res_found_q <= '0;
		end else begin
			if (cmd.cap_data) begin
				res_data_q <= rd_q;
			end
			if (cmd.cap_found) begin
				res_found_q <= FOUND_W'(idx_q);
			end
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
	end

	// output register lets the next request start while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_data_q   <= data_wide[VALUE_W-1:0];
			out_found_q  <= res_found_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign rsp_valid          = out_valid_q;
	assign rsp_status         = out_status_q;
	assign rsp_data_out       = out_data_q;
	assign rsp_found_position = out_found_q;
	assign rsp_element_count  = out_count_q;

	always_comb begin
		sts.action    = act_q;
		case (act_q)
			ACT_INSERT: sts.bad = (pos_x > count_x) || (count_x >= XW'(CAPACITY));
			ACT_FIND:   sts.bad = 1'b0;
			default:    sts.bad = (pos_x >= count_x);
		endcase
		sts.ins_more  = idx_x > pos_x;
		sts.er_more   = (idx_x + XW'(1)) < count_x;
		sts.find_more = idx_x < count_x;
		sts.match     = rd_q == val_q;
		sts.out_busy  = out_valid_q && !rsp_ready;
	end

endmodule

/* design/plt_ctrl.sv */
// plt_ctrl: sequencer for insert, erase, get and find over the list memory.
// Issues plt_cmd_t to plt_datapath; depends on plt_pkg.
`timescale 1ns / 1ps

module plt_ctrl import plt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output plt_cmd_t cmd,
	input  plt_sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS_TEST,
		S_INS_WR,
		S_ER_CAP,
		S_ER_TEST,
		S_ER_WR,
		S_GET_CAP,
		S_FIND_TEST,
		S_FIND_CMP,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.idx_op = IDX_HOLD;
		cmd.rd_sel = RD_IDX;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.load_req = in_valid;
			end
			S_CHECK: begin
				if (sts.bad) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_BAD;
				end else begin
					case (sts.action)
						ACT_INSERT: cmd.idx_op = IDX_COUNT;
						ACT_FIND:   cmd.idx_op = IDX_ZERO;
						default: begin
							cmd.idx_op = IDX_POS;
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
						end
					endcase
				end
			end
			S_INS_TEST: begin
				if (sts.ins_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_M1;
				end else begin
					cmd.wr_en      = 1'b1;
					cmd.wr_val     = 1'b1;
					cmd.cnt_inc    = 1'b1;
					cmd.set_status = 1'b1;
				end
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = IDX_DEC;
			end
			S_ER_CAP: begin
				cmd.cap_data = 1'b1;
			end
			S_ER_TEST: begin
				if (sts.er_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_P1;
				end else begin
					cmd.cnt_dec    = 1'b1;
					cmd.set_status = 1'b1;
				end
			end
			S_ER_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = IDX_INC;
			end
			S_GET_CAP: begin
				cmd.cap_data   = 1'b1;
				cmd.set_status = 1'b1;
			end
			S_FIND_TEST: begin
				if (sts.find_more) begin
					cmd.rd_en = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOTFOUND;
				end
			end
			S_FIND_CMP: begin
				if (sts.match) begin
					cmd.cap_found  = 1'b1;
					cmd.set_status = 1'b1;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			S_FINISH: begin
				cmd.out_load = !sts.out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.bad) begin
						state_q <= S_FINISH;
					end else begin
						case (sts.action)
							ACT_INSERT: state_q <= S_INS_TEST;
							ACT_ERASE:  state_q <= S_ER_CAP;
							ACT_GET:    state_q <= S_GET_CAP;
							default:    state_q <= S_FIND_TEST;
						endcase
					end
				end
				S_INS_TEST:  state_q <= sts.ins_more ? S_INS_WR : S_FINISH;
				S_INS_WR:    state_q <= S_INS_TEST;
				S_ER_CAP:    state_q <= S_ER_TEST;
				S_ER_TEST:   state_q <= sts.er_more ? S_ER_WR : S_FINISH;
				S_ER_WR:     state_q <= S_ER_TEST;
				S_GET_CAP:   state_q <= S_FINISH;
				S_FIND_TEST: state_q <= sts.find_more ? S_FIND_CMP : S_FINISH;
				S_FIND_CMP:  state_q <= sts.match ? S_FINISH : S_FIND_TEST;
				S_FINISH: begin
					if (!sts.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/positional_list_table.sv */
// channel | modport    | payload
// req     | plt_in_if  | action, position, value
// rsp     | plt_out_if | status, data_out, found_position, element_count
//
// one request at a time; all entry moves go through the single list memory,
// one read and one write per shifted entry
// arst_n clears the count and control; list contents are not cleared
// req is accepted once the previous result is in the output register,
// so a stalled rsp holds at most one request in progress behind it
//
// Top level of the positional list table; uses plt_pkg, plt_if, plt_ctrl
// and plt_datapath.
`timescale 1ns / 1ps

module positional_list_table import plt_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	plt_in_if.sink     req,
	plt_out_if.source  rsp
);

	plt_cmd_t cmd;
	plt_sts_t sts;
	logic     in_ready;

	assign req.ready = in_ready;

	plt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	plt_datapath #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.req_action         (req.action),
		.req_position       (req.position),
		.req_value          (req.value),
		.rsp_valid          (rsp.valid),
		.rsp_ready          (rsp.ready),
		.rsp_status         (rsp.status),
		.rsp_data_out       (rsp.data_out),
		.rsp_found_position (rsp.found_position),
		.rsp_element_count  (rsp.element_count)
	);

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for positional_list_table, with directed and random
// request streams, a built-in list predictor and random stalls on both channels.
// Depends on plt_pkg, plt_if and the positional_list_table RTL.
`timescale 1ns / 1ps

module tb_top;
	import plt_pkg::*;

	localparam int LIST_CAP = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int CALM_ITEMS = 100;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		action_t              action;
		logic [POS_W-1:0]     position;
		logic [VALUE_W-1:0]   value;
		int                   gap;
		bit                   drain_first;
		bit                   calm;
	} list_req_t;

	typedef struct {
		status_t              status;
		logic [VALUE_W-1:0]   data;
		logic [FOUND_W-1:0]   found;
		logic [COUNT_W-1:0]   count;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	plt_in_if  req_ch ();
	plt_out_if rsp_ch ();

	positional_list_table #(
		.CAPACITY   (LIST_CAP),
		.ELEM_WIDTH (32)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// shadow of the list as the block should hold it
	logic [VALUE_W-1:0] shadow_entries [LIST_CAP];
	int                 shadow_len;

	list_req_t pending_reqs [$];
	list_rsp_t results_due [$];
	int        fails;

	// generator bookkeeping, tracks the list length as requests are queued
	int                 gen_len;
	int                 gen_items;
	bit                 gen_idle;
	bit                 gen_drain;
	bit                 gen_calm;
	logic [VALUE_W-1:0] value_pool [$];

	function automatic list_rsp_t apply_list_op(action_t act, logic [POS_W-1:0] pos,
		logic [VALUE_W-1:0] val);
		list_rsp_t r;
		int i;
		bit hit;
		r.status = ST_OK;
		r.data = '0;
		r.found = '0;
		hit = 1'b0;
		case (act)
			ACT_INSERT: begin
				if (int'(pos) > shadow_len || shadow_len >= LIST_CAP) begin
					r.status = ST_BAD;
				end else begin
					for (i = shadow_len; i > int'(pos); i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[pos] = val;
					shadow_len++;
				end
			end
			ACT_ERASE: begin
				if (int'(pos) >= shadow_len) begin
					r.status = ST_BAD;
				end else begin
					r.data = shadow_entries[pos];
					for (i = int'(pos); i + 1 < shadow_len; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_len--;
				end
			end
			ACT_GET: begin
				if (int'(pos) >= shadow_len)
					r.status = ST_BAD;
				else
					r.data = shadow_entries[pos];
			end
			default: begin
				// lowest matching position wins
				for (i = 0; i < shadow_len && !hit; i++) begin
					if (shadow_entries[i] == val) begin
						hit = 1'b1;
						r.found = i[FOUND_W-1:0];
					end
				end
				if (!hit)
					r.status = ST_NOTFOUND;
			end
		endcase
		r.count = shadow_len[COUNT_W-1:0];
		return r;
	endfunction

	function automatic void queue_req(action_t act, int pos, logic [VALUE_W-1:0] val);
		list_req_t q;
		q.action = act;
		q.position = POS_W'(pos);
		q.value = val;
		q.gap = 0;
		if (!gen_calm && gen_idle && $urandom_range(0, 3) == 0)
			q.gap = $urandom_range(1, 19);
		q.drain_first = gen_drain;
		q.calm = gen_calm;
		gen_drain = 1'b0;
		pending_reqs.insert(pending_reqs.size(), q);
		gen_items++;
		if (act == ACT_INSERT && pos <= gen_len && gen_len < LIST_CAP) begin
			gen_len++;
			value_pool.insert(value_pool.size(), val);
			if (value_pool.size() > 32)
				void'(value_pool.pop_front());
		end else if (act == ACT_ERASE && pos < gen_len) begin
			gen_len--;
		end
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return VALUE_W'($urandom_range(0, 3));
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return 32'h0;
				endcase
			end
			2, 3: begin
				if (value_pool.size() > 0)
					return value_pool[$urandom_range(0, value_pool.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	// request driver
	list_req_t cur_req;
	bit        have_req;
	int        gap_left;
	bit        calm_phase;
	bit        show_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.action <= ACT_INSERT;
			req_ch.position <= '0;
			req_ch.value <= '0;
			have_req = 1'b0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				results_due.insert(results_due.size(),
					apply_list_op(cur_req.action, cur_req.position, cur_req.value));
				have_req = 1'b0;
			end
			if (have_req && gap_left > 0)
				gap_left--;
			if (!have_req && pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				have_req = 1'b1;
				gap_left = cur_req.gap;
				if (cur_req.calm)
					calm_phase = 1'b1;
			end
			show_req = have_req && gap_left == 0 &&
				!(cur_req.drain_first && results_due.size() > 0);
			req_ch.valid <= show_req;
			if (have_req) begin
				req_ch.action <= cur_req.action;
				req_ch.position <= cur_req.position;
				req_ch.value <= cur_req.value;
			end
		end
	end

	// response monitor
	list_rsp_t want;
	int        stall_left;
	int        rsp_cycle;

	task automatic check_field(string name, logic [VALUE_W-1:0] exp_v,
		logic [VALUE_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			rsp_cycle = 0;
		end else begin
			rsp_cycle++;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no request outstanding");
					fails++;
				end else begin
					want = results_due.pop_front();
					check_field("status", VALUE_W'(want.status), VALUE_W'(rsp_ch.status));
					check_field("data_out", want.data, rsp_ch.data_out);
					check_field("found_position", VALUE_W'(want.found),
						VALUE_W'(rsp_ch.found_position));
					check_field("element_count", VALUE_W'(want.count),
						VALUE_W'(rsp_ch.element_count));
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (!calm_phase && (rsp_cycle % 600) >= 200 && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 19);
			rsp_ch.ready <= (stall_left == 0);
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int k;
		int n;
		int p;
		arst_n = 1'b0;
		gen_len = 0;
		gen_items = 0;
		gen_idle = 1'b0;
		gen_drain = 1'b0;
		gen_calm = 1'b0;

		// empty list: every requested position is out of range, nothing to find
		queue_req(ACT_GET, 0, 32'h0);
		queue_req(ACT_ERASE, 0, 32'h0);
		queue_req(ACT_FIND, 31, 32'h5);
		queue_req(ACT_INSERT, 1, 32'h1);
		queue_req(ACT_INSERT, 31, 32'hdead_beef);
		// fill to capacity with extremes and a duplicate pair
		for (k = 0; k < LIST_CAP; k++) begin
			case (k)
				0: queue_req(ACT_INSERT, 0, 32'h8000_0000);
				1, 2: queue_req(ACT_INSERT, $urandom_range(0, k), 32'h7fff_ffff);
				3: queue_req(ACT_INSERT, $urandom_range(0, k), 32'hffff_ffff);
				4: queue_req(ACT_INSERT, $urandom_range(0, k), 32'h0);
				LIST_CAP - 1: queue_req(ACT_INSERT, k, 32'h5a5a_5a5a);
				default: queue_req(ACT_INSERT, $urandom_range(0, k), $urandom);
			endcase
		end
		queue_req(ACT_INSERT, 16, 32'h1234_5678);
		queue_req(ACT_GET, 15, 32'h0);
		queue_req(ACT_FIND, 0, 32'h5a5a_5a5a);
		queue_req(ACT_FIND, 0, 32'h7fff_ffff);
		queue_req(ACT_ERASE, 0, 32'h0);
		queue_req(ACT_GET, 16, 32'h0);

		gen_items = 0;
		gen_drain = 1'b1;
		while (gen_items < RANDOM_ITEMS) begin
			if (gen_items >= RANDOM_ITEMS - CALM_ITEMS)
				gen_calm = 1'b1;
			if ($urandom_range(0, 5) == 0)
				gen_idle = !gen_idle;
			if (gen_items % 150 == 149)
				gen_drain = 1'b1;
			case ($urandom_range(0, 9))
				0, 1: begin
					while (gen_len < LIST_CAP)
						queue_req(ACT_INSERT, $urandom_range(0, gen_len), pick_value());
					queue_req(ACT_INSERT, $urandom_range(0, LIST_CAP), pick_value());
					for (k = 0; k < 3; k++)
						queue_req(ACT_FIND, $urandom_range(0, 31), pick_value());
				end
				2: begin
					while (gen_len > 0)
						queue_req($urandom_range(0, 3) == 0 ? ACT_GET : ACT_ERASE,
							$urandom_range(0, gen_len - 1), pick_value());
					queue_req($urandom_range(0, 1) ? ACT_GET : ACT_ERASE,
						$urandom_range(0, 31), $urandom);
				end
				3: begin
					for (k = 0; k < 4; k++)
						queue_req(action_t'($urandom_range(0, 3)), $urandom_range(0, 31),
							$urandom);
				end
				default: begin
					n = $urandom_range(4, 12);
					for (k = 0; k < n; k++) begin
						case ($urandom_range(0, 3))
							0: begin
								p = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31)
									: $urandom_range(0, gen_len);
								queue_req(ACT_INSERT, p, pick_value());
							end
							1: begin
								p = (gen_len == 0 || $urandom_range(0, 7) == 0)
									? $urandom_range(0, 31) : $urandom_range(0, gen_len - 1);
								queue_req(ACT_ERASE, p, pick_value());
							end
							2: begin
								p = (gen_len == 0 || $urandom_range(0, 7) == 0)
									? $urandom_range(0, 31) : $urandom_range(0, gen_len - 1);
								queue_req(ACT_GET, p, pick_value());
							end
							default: queue_req(ACT_FIND, $urandom_range(0, 31), pick_value());
						endcase
					end
				end
			endcase
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() > 0 || have_req || results_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0 && results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
